// ===== design/rsc_pkg.sv =====
// Shared types, constants and helper functions of the rectangle segment clipper.
`timescale 1ns / 1ps
`default_nettype none
package rsc_pkg;

  localparam int CW      = 16;                          // coordinate width
  localparam int DW      = CW + 1;                      // coordinate difference width
  localparam int UW      = 2 * CW + 3;                  // line function width
  localparam int DSTEP   = 4;                           // quotient bits per divider stage
  localparam int DSTAGES = (UW + DSTEP - 1) / DSTEP;    // divider step stages
  localparam int NPW     = DSTAGES * DSTEP;             // padded dividend width

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [UW-1:0] wide_t;

  typedef enum logic [1:0] {
    SIDE_LEFT,
    SIDE_TOP,
    SIDE_RIGHT,
    SIDE_BOTTOM
  } side_t;

  typedef enum logic [1:0] {
    REG_LEFT,
    REG_RIGHT,
    REG_BOTTOM,
    REG_TOP
  } reg_idx_t;

  localparam coord_t LEFT_RST   = coord_t'(0);
  localparam coord_t RIGHT_RST  = coord_t'(639);
  localparam coord_t BOTTOM_RST = coord_t'(0);
  localparam coord_t TOP_RST    = coord_t'(479);

  typedef struct packed {
    coord_t l;
    coord_t r;
    coord_t b;
    coord_t t;
  } window_t;

  typedef struct packed {
    coord_t x1;
    coord_t y1;
    coord_t x2;
    coord_t y2;
    logic   vis;       // not trivially rejected
    logic   general;   // neither horizontal nor vertical
    logic   crossed;   // some corner sign change seen
  } item_t;

  typedef struct packed {
    logic do_move;
    logic tgt2;        // move the upper endpoint
    logic axis_y;      // quotient is a y coordinate
    logic den_zero;
  } move_t;

  typedef struct packed {
    item_t item;
    move_t move;
  } band_t;

  typedef struct packed {
    logic [DW-1:0]  rem;
    logic [NPW-1:0] mq;
  } div_state_t;

  // DSTEP restoring division steps; dividend shifts out of mq, quotient shifts in
  function automatic div_state_t div_steps(div_state_t s, logic [DW-1:0] dm);
    div_state_t r;
    logic [DW:0] t;
    r = s;
    for (int i = 0; i < DSTEP; i++) begin
      t = {r.rem, r.mq[NPW-1]};
      r.mq = {r.mq[NPW-2:0], 1'b0};
      if (t >= {1'b0, dm}) begin
        t = t - {1'b0, dm};
        r.mq[0] = 1'b1;
      end
      r.rem = t[DW-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== design/rsc_divider.sv =====
// Pipelined signed divider, truncating toward zero, quotient saturated to a coordinate.
`timescale 1ns / 1ps
`default_nettype none
module rsc_divider (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           en,
  input  wire logic           in_valid,
  input  wire rsc_pkg::wide_t num,
  input  wire rsc_pkg::diff_t den,
  input  wire rsc_pkg::band_t in_band,
  output logic                out_valid,
  output rsc_pkg::coord_t     quo,
  output rsc_pkg::band_t      out_band
);

  localparam logic [rsc_pkg::NPW-1:0] LIM_NEG =
    rsc_pkg::NPW'(64'd1 << (rsc_pkg::CW - 1));
  localparam logic [rsc_pkg::NPW-1:0] LIM_POS = LIM_NEG - rsc_pkg::NPW'(1);

  rsc_pkg::div_state_t      st     [rsc_pkg::DSTAGES+1];
  logic [rsc_pkg::DW-1:0]   dm_s   [rsc_pkg::DSTAGES+1];
  logic                     neg_s  [rsc_pkg::DSTAGES+1];
  logic                     v_s    [rsc_pkg::DSTAGES+1];
  rsc_pkg::band_t           band_s [rsc_pkg::DSTAGES+1];

  logic [rsc_pkg::UW-1:0] nmag;
  logic [rsc_pkg::DW-1:0] dmag;

  always_comb begin
    nmag = num[rsc_pkg::UW-1] ? ('0 - rsc_pkg::UW'(num)) : rsc_pkg::UW'(num);
    dmag = den[rsc_pkg::DW-1] ? ('0 - rsc_pkg::DW'(den)) : rsc_pkg::DW'(den);
  end

  // sign/magnitude stage
  always_ff @(posedge clk) begin
    if (rst) begin
      v_s[0] <= 1'b0;
    end else if (en) begin
      v_s[0] <= in_valid;
    end
    if (en) begin
      st[0].rem <= '0;
      st[0].mq  <= rsc_pkg::NPW'(nmag);
      dm_s[0]   <= dmag;
      neg_s[0]  <= num[rsc_pkg::UW-1] ^ den[rsc_pkg::DW-1];
      band_s[0] <= in_band;
    end
  end

  for (genvar k = 0; k < rsc_pkg::DSTAGES; k++) begin : g_step
    rsc_pkg::div_state_t nx;
    always_comb nx = rsc_pkg::div_steps(st[k], dm_s[k]);
    always_ff @(posedge clk) begin
      if (rst) begin
        v_s[k+1] <= 1'b0;
      end else if (en) begin
        v_s[k+1] <= v_s[k];
      end
      if (en) begin
        st[k+1]     <= nx;
        dm_s[k+1]   <= dm_s[k];
        neg_s[k+1]  <= neg_s[k];
        band_s[k+1] <= band_s[k];
      end
    end
  end

  logic [rsc_pkg::NPW-1:0] q;
  logic [rsc_pkg::NPW-1:0] lim;
  logic [rsc_pkg::NPW-1:0] qs;
  logic [rsc_pkg::NPW-1:0] qn;

  always_comb begin
    q   = st[rsc_pkg::DSTAGES].mq;
    lim = neg_s[rsc_pkg::DSTAGES] ? LIM_NEG : LIM_POS;
    qs  = (q > lim) ? lim : q;
    qn  = '0 - qs;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v_s[rsc_pkg::DSTAGES];
    end
    if (en) begin
      quo      <= neg_s[rsc_pkg::DSTAGES] ? rsc_pkg::coord_t'(qn[rsc_pkg::CW-1:0])
                                          : rsc_pkg::coord_t'(qs[rsc_pkg::CW-1:0]);
      out_band <= band_s[rsc_pkg::DSTAGES];
    end
  end

endmodule
`default_nettype wire

// ===== design/rsc_front.sv =====
// Front stages: trivial reject, ordering by y, clamping of flat segments.
`timescale 1ns / 1ps
`default_nettype none
module rsc_front (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire rsc_pkg::window_t win,
  input  wire logic             in_valid,
  input  wire rsc_pkg::coord_t  sx,
  input  wire rsc_pkg::coord_t  sy,
  input  wire rsc_pkg::coord_t  ex,
  input  wire rsc_pkg::coord_t  ey,
  output logic                  out_valid,
  output rsc_pkg::item_t        out_item
);

  logic            v1;
  logic            rej1;
  rsc_pkg::coord_t ax, ay, bx, by;
  logic            rej;

  always_comb begin
    rej = (sx < win.l && ex < win.l) || (sx > win.r && ex > win.r) ||
          (sy < win.b && ey < win.b) || (sy > win.t && ey > win.t);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
    end
    if (en) begin
      ax   <= sx;
      ay   <= sy;
      bx   <= ex;
      by   <= ey;
      rej1 <= rej;
    end
  end

  rsc_pkg::item_t it;
  rsc_pkg::coord_t tx;

  always_comb begin
    it.x1 = ax;
    it.y1 = ay;
    it.x2 = bx;
    it.y2 = by;
    if (ay > by) begin
      it.x1 = bx;
      it.y1 = by;
      it.x2 = ax;
      it.y2 = ay;
    end
    tx = it.x1;
    if (it.y1 == it.y2) begin
      if (it.x1 > it.x2) begin
        it.x1 = it.x2;
        it.x2 = tx;
      end
      if (it.x1 < win.l) it.x1 = win.l;
      if (it.x2 > win.r) it.x2 = win.r;
    end else if (it.x1 == it.x2) begin
      if (it.y1 < win.b) it.y1 = win.b;
      if (it.y2 > win.t) it.y2 = win.t;
    end
    it.vis     = !rej1;
    it.general = !rej1 && (ay != by) && (ax != bx);
    it.crossed = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= v1;
    end
    if (en) begin
      out_item <= it;
    end
  end

endmodule
`default_nettype wire

// ===== design/rsc_side.sv =====
// One window side: corner sign test, endpoint move through the divider.
`timescale 1ns / 1ps
`default_nettype none
module rsc_side (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             en,
  input  wire rsc_pkg::side_t   side,
  input  wire rsc_pkg::window_t win,
  input  wire logic             in_valid,
  input  wire rsc_pkg::item_t   in_item,
  output logic                  out_valid,
  output rsc_pkg::item_t        out_item
);

  // stage A: differences
  logic           va;
  rsc_pkg::item_t ia;
  rsc_pkg::diff_t dxa, dya;

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= 1'b0;
    end else if (en) begin
      va <= in_valid;
    end
    if (en) begin
      ia  <= in_item;
      dxa <= rsc_pkg::diff_t'(in_item.x1) - rsc_pkg::diff_t'(in_item.x2);
      dya <= rsc_pkg::diff_t'(in_item.y1) - rsc_pkg::diff_t'(in_item.y2);
    end
  end

  // corners in order left-top-right-bottom; corner a then corner b
  rsc_pkg::coord_t cxa, cya, cxb, cyb;

  always_comb begin
    case (side)
      rsc_pkg::SIDE_LEFT: begin
        cxa = win.l; cya = win.b; cxb = win.l; cyb = win.t;
      end
      rsc_pkg::SIDE_TOP: begin
        cxa = win.l; cya = win.t; cxb = win.r; cyb = win.t;
      end
      rsc_pkg::SIDE_RIGHT: begin
        cxa = win.r; cya = win.t; cxb = win.r; cyb = win.b;
      end
      default: begin
        cxa = win.r; cya = win.b; cxb = win.l; cyb = win.b;
      end
    endcase
  end

  // stage B: products
  logic           vb;
  rsc_pkg::item_t ib;
  rsc_pkg::diff_t dxb, dyb;
  rsc_pkg::wide_t pxa, pya, pxb, pyb, c1, c2;

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= 1'b0;
    end else if (en) begin
      vb <= va;
    end
    if (en) begin
      ib  <= ia;
      dxb <= dxa;
      dyb <= dya;
      pxa <= rsc_pkg::wide_t'(cxa) * rsc_pkg::wide_t'(dya);
      pya <= rsc_pkg::wide_t'(cya) * rsc_pkg::wide_t'(dxa);
      pxb <= rsc_pkg::wide_t'(cxb) * rsc_pkg::wide_t'(dya);
      pyb <= rsc_pkg::wide_t'(cyb) * rsc_pkg::wide_t'(dxa);
      c1  <= rsc_pkg::wide_t'(ia.x1) * rsc_pkg::wide_t'(ia.y2);
      c2  <= rsc_pkg::wide_t'(ia.y1) * rsc_pkg::wide_t'(ia.x2);
    end
  end

  // stage C: signs, move decision, divider operands
  rsc_pkg::wide_t ua, ub, num;
  rsc_pkg::diff_t den;
  logic           pa, pb, chg;
  rsc_pkg::band_t bnd;

  always_comb begin
    ua  = pxa - pya + c1 - c2;
    ub  = pxb - pyb + c1 - c2;
    pa  = !ua[rsc_pkg::UW-1] && (ua != '0);
    pb  = !ub[rsc_pkg::UW-1] && (ub != '0);
    chg = ib.general && (pa != pb);
    bnd.item = ib;
    bnd.item.crossed = ib.crossed | chg;
    bnd.move = '0;
    num = pxa + c1 - c2;
    den = dxb;
    case (side)
      rsc_pkg::SIDE_LEFT: begin
        bnd.move.axis_y = 1'b1;
        if (chg && ib.x1 < win.l) begin
          bnd.move.do_move = 1'b1;
        end else if (chg && ib.x2 < win.l) begin
          bnd.move.do_move = 1'b1;
          bnd.move.tgt2    = 1'b1;
        end
      end
      rsc_pkg::SIDE_RIGHT: begin
        bnd.move.axis_y = 1'b1;
        if (chg && ib.x1 > win.r) begin
          bnd.move.do_move = 1'b1;
        end else if (chg && ib.x2 > win.r) begin
          bnd.move.do_move = 1'b1;
          bnd.move.tgt2    = 1'b1;
        end
      end
      rsc_pkg::SIDE_TOP: begin
        num = pya - c1 + c2;
        den = dyb;
        bnd.move.tgt2 = 1'b1;
        bnd.move.do_move = chg && (ib.y2 > win.t);
      end
      default: begin
        num = pya - c1 + c2;
        den = dyb;
        bnd.move.do_move = chg && (ib.y1 < win.b);
      end
    endcase
    bnd.move.den_zero = (den == '0);
  end

  logic           vc;
  rsc_pkg::band_t bc;
  rsc_pkg::wide_t numc;
  rsc_pkg::diff_t denc;

  always_ff @(posedge clk) begin
    if (rst) begin
      vc <= 1'b0;
    end else if (en) begin
      vc <= vb;
    end
    if (en) begin
      bc   <= bnd;
      numc <= num;
      denc <= den;
    end
  end

  logic            vq;
  rsc_pkg::coord_t quo;
  rsc_pkg::band_t  bq;

  rsc_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .in_valid (vc),
    .num      (numc),
    .den      (denc),
    .in_band  (bc),
    .out_valid(vq),
    .quo      (quo),
    .out_band (bq)
  );

  // stage D: write the moved endpoint back
  rsc_pkg::coord_t ev;
  rsc_pkg::item_t  it;

  always_comb begin
    case (side)
      rsc_pkg::SIDE_LEFT:  ev = win.l;
      rsc_pkg::SIDE_TOP:   ev = win.t;
      rsc_pkg::SIDE_RIGHT: ev = win.r;
      default:             ev = win.b;
    endcase
    it = bq.item;
    if (bq.move.do_move) begin
      if (bq.move.axis_y) begin
        if (bq.move.tgt2) begin
          it.x2 = ev;
          if (!bq.move.den_zero) it.y2 = quo;
        end else begin
          it.x1 = ev;
          if (!bq.move.den_zero) it.y1 = quo;
        end
      end else begin
        if (bq.move.tgt2) begin
          it.y2 = ev;
          if (!bq.move.den_zero) it.x2 = quo;
        end else begin
          it.y1 = ev;
          if (!bq.move.den_zero) it.x1 = quo;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vq;
    end
    if (en) begin
      out_item <= it;
    end
  end

endmodule
`default_nettype wire

// ===== design/rectangle_segment_clipper_core.sv =====
// Top level of the rectangle segment clipper: window registers, clip pipeline, output register.
`timescale 1ns / 1ps
`default_nettype none
// Clips one segment per transaction against the window held in four registers
// (left, right, bottom, top) and returns a visible flag with the clipped
// endpoints ordered by y; rejected segments return all-zero coordinates.
// One segment is accepted every clock while the result channel does not stall;
// each segment passes 2 front stages (reject, ordering, flat clamping),
// then 15 stages for each of the four window sides in turn (differences,
// products, sign test, an 11-stage restoring divider made of an operand sign
// stage, nine stages that resolve 4 quotient bits each and a saturation
// stage, write-back), then the output register.
// A stall on the result channel freezes the whole pipeline; seg_stall is
// then high. cfg_ready is always high; write the window only when idle.
module rectangle_segment_clipper_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  // configuration writes
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [1:0]             cfg_index,
  input  wire logic [rsc_pkg::CW-1:0] cfg_data,
  // segment transactions
  input  wire logic                   seg_valid,
  output logic                        seg_stall,
  input  wire rsc_pkg::coord_t        start_x,
  input  wire rsc_pkg::coord_t        start_y,
  input  wire rsc_pkg::coord_t        end_x,
  input  wire rsc_pkg::coord_t        end_y,
  // clipped results
  output logic                        clip_valid,
  input  wire logic                   clip_stall,
  output logic                        visible,
  output rsc_pkg::coord_t             lower_x,
  output rsc_pkg::coord_t             lower_y,
  output rsc_pkg::coord_t             upper_x,
  output rsc_pkg::coord_t             upper_y
);

  rsc_pkg::window_t win;
  logic             en;

  assign cfg_ready = 1'b1;
  // global advance: everything moves unless a finished result is held
  assign en        = !clip_valid || !clip_stall;
  assign seg_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      win.l <= rsc_pkg::LEFT_RST;
      win.r <= rsc_pkg::RIGHT_RST;
      win.b <= rsc_pkg::BOTTOM_RST;
      win.t <= rsc_pkg::TOP_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (rsc_pkg::reg_idx_t'(cfg_index))
        rsc_pkg::REG_LEFT:   win.l <= rsc_pkg::coord_t'(cfg_data);
        rsc_pkg::REG_RIGHT:  win.r <= rsc_pkg::coord_t'(cfg_data);
        rsc_pkg::REG_BOTTOM: win.b <= rsc_pkg::coord_t'(cfg_data);
        rsc_pkg::REG_TOP:    win.t <= rsc_pkg::coord_t'(cfg_data);
        default: ;
      endcase
    end
  end

  logic           v [5];
  rsc_pkg::item_t it [5];

  rsc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .en       (en),
    .win      (win),
    .in_valid (seg_valid),
    .sx       (start_x),
    .sy       (start_y),
    .ex       (end_x),
    .ey       (end_y),
    .out_valid(v[0]),
    .out_item (it[0])
  );

  // sides visited in corner order: left, top, right, bottom
  rsc_side u_left (
    .clk(clk), .rst(rst), .en(en), .side(rsc_pkg::SIDE_LEFT), .win(win),
    .in_valid(v[0]), .in_item(it[0]), .out_valid(v[1]), .out_item(it[1])
  );

  rsc_side u_top (
    .clk(clk), .rst(rst), .en(en), .side(rsc_pkg::SIDE_TOP), .win(win),
    .in_valid(v[1]), .in_item(it[1]), .out_valid(v[2]), .out_item(it[2])
  );

  rsc_side u_right (
    .clk(clk), .rst(rst), .en(en), .side(rsc_pkg::SIDE_RIGHT), .win(win),
    .in_valid(v[2]), .in_item(it[2]), .out_valid(v[3]), .out_item(it[3])
  );

  rsc_side u_bottom (
    .clk(clk), .rst(rst), .en(en), .side(rsc_pkg::SIDE_BOTTOM), .win(win),
    .in_valid(v[3]), .in_item(it[3]), .out_valid(v[4]), .out_item(it[4])
  );

  // general segments are visible only if some corner sign change was seen
  logic vis;

  always_comb begin
    vis = it[4].general ? it[4].crossed : it[4].vis;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clip_valid <= 1'b0;
    end else if (en) begin
      clip_valid <= v[4];
    end
    if (en) begin
      visible <= vis;
      lower_x <= vis ? it[4].x1 : '0;
      lower_y <= vis ? it[4].y1 : '0;
      upper_x <= vis ? it[4].x2 : '0;
      upper_y <= vis ? it[4].y2 : '0;
    end
  end

  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    clip_valid && !visible |-> lower_x == '0 && lower_y == '0 &&
                               upper_x == '0 && upper_y == '0)
    else $error("rejected segment with nonzero coordinates");

  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    seg_stall |-> clip_valid && clip_stall)
    else $error("input stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !clip_valid)
    else $error("result valid right after reset");

endmodule
`default_nettype wire

// ===== dv/rectangle_segment_clipper_checker.sv =====
// Checker for the segment clipper: predicts each clipped result and compares it with the DUT output.
`timescale 1ns / 1ps
module rectangle_segment_clipper_checker (
  input  logic            clk,
  input  logic            rst,
  input  logic            cfg_valid,
  input  logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  rsc_pkg::coord_t cfg_data,
  input  logic            seg_valid,
  input  logic            seg_stall,
  input  rsc_pkg::coord_t start_x,
  input  rsc_pkg::coord_t start_y,
  input  rsc_pkg::coord_t end_x,
  input  rsc_pkg::coord_t end_y,
  input  logic            clip_valid,
  input  logic            clip_stall,
  input  logic            visible,
  input  rsc_pkg::coord_t lower_x,
  input  rsc_pkg::coord_t lower_y,
  input  rsc_pkg::coord_t upper_x,
  input  rsc_pkg::coord_t upper_y,
  output int              pending,
  output int              errors
);

  typedef struct packed {
    logic            vis;
    rsc_pkg::coord_t lx, ly, ux, uy;
  } clip_res_t;

  clip_res_t      clip_q[$];
  longint signed  win_l, win_r, win_b, win_t;

  assign pending = clip_q.size();

  // line function U(X,Y) = X*dy - Y*dx + (x1*y2 - y1*x2), all in 128 bits
  function automatic logic signed [127:0] cross_of(longint signed x1, y1, x2, y2);
    return 128'(x1) * 128'(y2) - 128'(y1) * 128'(x2);
  endfunction

  function automatic bit pos_at(longint signed x1, y1, x2, y2, px, py);
    logic signed [127:0] u;
    u = 128'(px) * 128'(y1 - y2) - 128'(py) * 128'(x1 - x2) + cross_of(x1, y1, x2, y2);
    return u > 0;
  endfunction

  // truncating division, saturated to the coordinate range
  function automatic longint signed sat_div(logic signed [127:0] n, longint signed d);
    logic signed [127:0] q;
    q = n / 128'(d);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return longint'(q);
  endfunction

  function automatic longint signed y_on(longint signed x1, y1, x2, y2, px, keep);
    if (x1 == x2) return keep;
    return sat_div(128'(px) * 128'(y1 - y2) + cross_of(x1, y1, x2, y2), x1 - x2);
  endfunction

  function automatic longint signed x_on(longint signed x1, y1, x2, y2, py, keep);
    if (y1 == y2) return keep;
    return sat_div(128'(py) * 128'(x1 - x2) - cross_of(x1, y1, x2, y2), y1 - y2);
  endfunction

  function automatic clip_res_t clip_segment(longint signed x1, y1, x2, y2);
    longint signed l, r, b, t, tmp;
    bit vis;
    int hits;
    clip_res_t res;
    l = win_l; r = win_r; b = win_b; t = win_t;
    vis = 1; hits = 0;
    if ((x1 < l && x2 < l) || (x1 > r && x2 > r) || (y1 < b && y2 < b) ||
        (y1 > t && y2 > t)) begin
      vis = 0;
    end else begin
      if (y1 > y2) begin
        tmp = x1; x1 = x2; x2 = tmp; tmp = y1; y1 = y2; y2 = tmp;
      end
      if (y1 == y2) begin
        if (x1 > x2) begin tmp = x1; x1 = x2; x2 = tmp; end
        if (x1 < l) x1 = l;
        if (x2 > r) x2 = r;
      end else if (x1 == x2) begin
        if (y1 < b) y1 = b;
        if (y2 > t) y2 = t;
      end else begin
        // corners walked left, top, right, bottom
        if (pos_at(x1, y1, x2, y2, l, b) != pos_at(x1, y1, x2, y2, l, t)) begin
          hits++;
          if (x1 < l) begin y1 = y_on(x1, y1, x2, y2, l, y1); x1 = l; end
          else if (x2 < l) begin y2 = y_on(x1, y1, x2, y2, l, y2); x2 = l; end
        end
        if (pos_at(x1, y1, x2, y2, l, t) != pos_at(x1, y1, x2, y2, r, t)) begin
          hits++;
          if (y2 > t) begin x2 = x_on(x1, y1, x2, y2, t, x2); y2 = t; end
        end
        if (pos_at(x1, y1, x2, y2, r, t) != pos_at(x1, y1, x2, y2, r, b)) begin
          hits++;
          if (x1 > r) begin y1 = y_on(x1, y1, x2, y2, r, y1); x1 = r; end
          else if (x2 > r) begin y2 = y_on(x1, y1, x2, y2, r, y2); x2 = r; end
        end
        if (pos_at(x1, y1, x2, y2, r, b) != pos_at(x1, y1, x2, y2, l, b)) begin
          hits++;
          if (y1 < b) begin x1 = x_on(x1, y1, x2, y2, b, x1); y1 = b; end
        end
        vis = hits > 0;
      end
    end
    if (!vis) begin x1 = 0; y1 = 0; x2 = 0; y2 = 0; end
    res.vis = vis;
    res.lx = rsc_pkg::coord_t'(x1); res.ly = rsc_pkg::coord_t'(y1);
    res.ux = rsc_pkg::coord_t'(x2); res.uy = rsc_pkg::coord_t'(y2);
    return res;
  endfunction

  always @(posedge clk) begin
    clip_res_t e;
    if (rst) begin
      win_l <= rsc_pkg::LEFT_RST;   win_r <= rsc_pkg::RIGHT_RST;
      win_b <= rsc_pkg::BOTTOM_RST; win_t <= rsc_pkg::TOP_RST;
      clip_q.delete();
      errors <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (rsc_pkg::reg_idx_t'(cfg_index))
          rsc_pkg::REG_LEFT:   win_l <= cfg_data;
          rsc_pkg::REG_RIGHT:  win_r <= cfg_data;
          rsc_pkg::REG_BOTTOM: win_b <= cfg_data;
          rsc_pkg::REG_TOP:    win_t <= cfg_data;
          default: ;
        endcase
      end
      if (seg_valid && !seg_stall)
        clip_q.push_back(clip_segment(start_x, start_y, end_x, end_y));
      if (clip_valid && !clip_stall) begin
        if (clip_q.size() == 0) begin
          $error("unexpected clip transaction");
          errors <= errors + 1;
        end else begin
          e = clip_q.pop_front();
          if (visible !== e.vis || lower_x !== e.lx || lower_y !== e.ly ||
              upper_x !== e.ux || upper_y !== e.uy)
            errors <= errors + 1;
          if (visible !== e.vis) $error("visible: exp %0d got %0d", e.vis, visible);
          if (lower_x !== e.lx) $error("lower_x: exp %0d got %0d", e.lx, lower_x);
          if (lower_y !== e.ly) $error("lower_y: exp %0d got %0d", e.ly, lower_y);
          if (upper_x !== e.ux) $error("upper_x: exp %0d got %0d", e.ux, upper_x);
          if (upper_y !== e.uy) $error("upper_y: exp %0d got %0d", e.uy, upper_y);
        end
      end
    end
  end
endmodule

// ===== dv/rectangle_segment_clipper_core_tb.sv =====
// Testbench top for the segment clipper: window setup, segment stimulus, verdict.
`timescale 1ns / 1ps
module rectangle_segment_clipper_core_tb;

  localparam int LATENCY    = 63;
  localparam int IDLE_LIMIT = 2000;  // cycles without any transaction

  logic   clk, rst;
  logic   cfg_valid, cfg_ready;
  logic [1:0] cfg_index;
  rsc_pkg::coord_t cfg_data;
  logic   seg_valid, seg_stall;
  rsc_pkg::coord_t start_x, start_y, end_x, end_y;
  logic   clip_valid, clip_stall, visible;
  rsc_pkg::coord_t lower_x, lower_y, upper_x, upper_y;
  int     pending, errors;
  int     quiet;
  bit     rx_hold;  // receiver stalls freely while set

  rectangle_segment_clipper_core uut (.*);
  rectangle_segment_clipper_checker chk (.*);

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // watchdog: counts cycles with no accepted transaction of any kind
  always @(posedge clk) begin
    if (rst || (seg_valid && !seg_stall) || (clip_valid && !clip_stall) ||
        (cfg_valid && cfg_ready))
      quiet <= 0;
    else
      quiet <= quiet + 1;
    if (quiet >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver: may stall before each result, with no-stall stretches
  initial begin
    int gap;
    clip_stall = 1'b0;
    @(negedge rst);
    forever begin
      gap = (rx_hold && $urandom_range(0, 3) != 0) ? $urandom_range(0, 9) : 0;
      if (gap > 0) begin
        @(posedge clk) clip_stall <= 1'b1;
        repeat (gap - 1) @(posedge clk);
        @(posedge clk) clip_stall <= 1'b0;
      end
      do @(posedge clk); while (!(clip_valid && !clip_stall));
    end
  end

  task automatic write_window(rsc_pkg::reg_idx_t idx, int value);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= rsc_pkg::coord_t'(value);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(int l, int r, int b, int t);
    write_window(rsc_pkg::REG_LEFT, l);
    write_window(rsc_pkg::REG_RIGHT, r);
    write_window(rsc_pkg::REG_BOTTOM, b);
    write_window(rsc_pkg::REG_TOP, t);
  endtask

  // stop sending and wait for the pipeline to empty out
  task automatic drain();
    seg_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  // one segment transaction; gap idle cycles first (none in busy mode).
  // Called at a clock edge; returns at the accepting edge with valid still
  // high so that the next segment can follow in the very next cycle.
  task automatic send_segment(int sx, int sy, int ex, int ey, bit gaps);
    int gap;
    gap = gaps ? $urandom_range(0, 9) : 0;
    if (gap > 0) begin
      seg_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    seg_valid <= 1'b1;
    start_x <= rsc_pkg::coord_t'(sx); start_y <= rsc_pkg::coord_t'(sy);
    end_x   <= rsc_pkg::coord_t'(ex); end_y   <= rsc_pkg::coord_t'(ey);
    do @(posedge clk); while (seg_stall);
  endtask

  // random coordinate: mostly near the window, sometimes anywhere
  function automatic int pick(int lo, int hi);
    case ($urandom_range(0, 5))
      0:       return $signed(16'($urandom));
      1:       return $urandom_range(0, 1) ? -32768 : 32767;
      default: return lo - 200 + int'($urandom_range(0, 400)) + ((hi - lo) > 0 ?
                 int'($urandom_range(0, (hi - lo) > 4000 ? 4000 : hi - lo)) : 0);
    endcase
  endfunction

  task automatic random_phase(int n, int l, int r, int b, int t);
    bit gaps;
    for (int i = 0; i < n; i++) begin
      if (i % 60 == 0) begin
        gaps    = $urandom_range(0, 3) != 0;  // some stretches run flat out
        rx_hold = $urandom_range(0, 3) != 0;
      end
      case ($urandom_range(0, 9))
        0: begin  // horizontal
             int y; y = pick(b, t);
             send_segment(pick(l, r), y, pick(l, r), y, gaps);
           end
        1: begin  // vertical
             int x; x = pick(l, r);
             send_segment(x, pick(b, t), x, pick(b, t), gaps);
           end
        default: send_segment(pick(l, r), pick(b, t), pick(l, r), pick(b, t), gaps);
      endcase
    end
  endtask

  initial begin
    rst = 1'b1;
    rx_hold = 1'b1;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    seg_valid = 1'b0;
    start_x = '0; start_y = '0; end_x = '0; end_y = '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed: reset window 0..639 x 0..479
    send_segment(-10, -10, -5, 600, 0);       // both left: reject
    send_segment(700, 10, 900, 20, 0);        // both right
    send_segment(10, 500, 20, 600, 0);        // both above
    send_segment(10, -5, 20, -1, 0);          // both below
    send_segment(-100, 50, 800, 50, 0);       // horizontal, clamped both ends
    send_segment(700, 50, -100, 50, 0);       // horizontal, reversed
    send_segment(30, 600, 30, -40, 0);        // vertical
    send_segment(-100, -100, 800, 600, 0);    // diagonal through window
    send_segment(100, 400, 600, 20, 0);       // fully inside
    send_segment(-300, 470, 10, 800, 0);      // general, misses corner: reject
    send_segment(-32768, -32768, 32767, 32767, 0);
    send_segment(32767, -32768, -32768, 32767, 0);
    send_segment(-32768, 0, 32767, 1, 0);
    send_segment(0, 0, 0, 0, 0);
    send_segment(639, 479, -1, -1, 0);
    // sender holds off until every expected result is back
    drain();

    random_phase(300, 0, 639, 0, 479);
    drain();
    set_window(-32768, 32767, -32768, 32767); // widest window
    send_segment(-32768, -32768, 32767, 32767, 0);
    send_segment(-32768, 32767, 32767, -32768, 0);
    send_segment(-32768, 5, 32767, 7, 0);
    random_phase(250, -32768, 32767, -32768, 32767);
    drain();
    set_window(100, 100, -50, -50);           // degenerate point window
    send_segment(0, -100, 200, 0, 0);
    send_segment(100, -60, 100, 60, 0);
    random_phase(150, 100, 100, -50, -50);
    drain();
    set_window(500, -500, 300, -300);         // inverted window
    random_phase(150, -500, 500, -300, 300);
    drain();
    set_window(32767, -32768, 32767, -32768); // inverted extremes
    send_segment(0, 0, 10, 20, 0);
    random_phase(100, -32768, 32767, -32768, 32767);
    drain();
    set_window(-1000, 3000, -2000, 1500);
    random_phase(180, -1000, 3000, -2000, 1500);

    drain();
    if (errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end
endmodule
